// ----- hdl/ptbf_pkg.sv -----
// ----------------------------------------------------------------------------
// ptbf_pkg: shared types and constants of the printer text byte filter
// Character codes, register indexes and controller/datapath link structs.
// ----------------------------------------------------------------------------
`default_nettype none

package ptbf_pkg;

  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 4;

  localparam logic [CfgIdxW-1:0] CFG_TAB_WIDTH    = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_BINARY_MODE  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_NO_FORM_FEED = 2'd2;

  localparam logic [3:0] TAB_WIDTH_RESET = 4'd4;

  // controller -> datapath
  typedef struct packed {
    logic load;   // capture the accepted request
    logic step;   // retire one result (or an item with none)
  } ptbf_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic empty;  // current item produces no result
    logic last;   // current result is the final one of the item
  } ptbf_sts_t;

endpackage

`default_nettype wire

// ----- hdl/ptbf_in_if.sv -----
// ----------------------------------------------------------------------------
// ptbf_in_if: input channel of the printer text byte filter
// Valid/ready handshake carrying one text byte or an end-of-file mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface ptbf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_file;

  modport source (output valid, output in_byte, output end_of_file, input ready);
  modport sink   (input valid, input in_byte, input end_of_file, output ready);
endinterface

`default_nettype wire

// ----- hdl/ptbf_out_if.sv -----
// ----------------------------------------------------------------------------
// ptbf_out_if: result channel of the printer text byte filter
// Valid/ready handshake carrying one printer byte and its end-of-run flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface ptbf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;

  modport source (output valid, output out_byte, output last_of_run, input ready);
  modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

`default_nettype wire

// ----- hdl/ptbf_ctrl.sv -----
// ----------------------------------------------------------------------------
// ptbf_ctrl: request sequencer of the printer text byte filter
// Takes one request, then walks the datapath through its results.
// ----------------------------------------------------------------------------
`default_nettype none

module ptbf_ctrl (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire                out_ready,
  output ptbf_pkg::ptbf_cmd_t cmd,
  input  ptbf_pkg::ptbf_sts_t sts
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    cmd.load  = 1'b0;
    cmd.step  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts.empty) begin
          // end of file with nothing to print: just clear the state
          cmd.step  = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          out_valid = 1'b1;
          if (out_ready) begin
            cmd.step = 1'b1;
            if (sts.last) begin
              state_nxt = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/ptbf_dp.sv -----
// ----------------------------------------------------------------------------
// ptbf_dp: datapath of the printer text byte filter
// Holds configuration, column and CR history; forms each printer byte.
// ----------------------------------------------------------------------------
`default_nettype none

module ptbf_dp (
  input  wire                                    clk,
  input  wire                                    rst_n,
  input  wire                                    cfg_we,
  input  wire  [ptbf_pkg::CfgIdxW-1:0]           cfg_index,
  input  wire  [ptbf_pkg::CfgDataW-1:0]          cfg_wdata,
  input  wire  [7:0]                             in_byte,
  input  wire                                    end_of_file,
  input  ptbf_pkg::ptbf_cmd_t                    cmd,
  output ptbf_pkg::ptbf_sts_t                    sts,
  output logic [7:0]                             out_byte
);

  logic [3:0] tab_width_r;
  logic       binary_mode_r;
  logic       no_form_feed_r;
  logic [7:0] byte_r;
  logic       eof_r;
  logic       lf_cr_sent_r, lf_cr_sent_nxt;
  logic [2:0] col_r, col_nxt;
  logic       prev_cr_r, prev_cr_nxt;

  logic       is_cr, is_lf, is_tab;
  logic [2:0] tab_mask;
  logic [2:0] col_inc;

  assign is_cr   = (byte_r == ptbf_pkg::CH_CR);
  assign is_lf   = (byte_r == ptbf_pkg::CH_LF);
  assign is_tab  = (byte_r == ptbf_pkg::CH_TAB);
  assign col_inc = col_r + 3'd1;

  always_comb begin
    unique case (tab_width_r)
      4'd1:    tab_mask = 3'd0;
      4'd2:    tab_mask = 3'd1;
      4'd4:    tab_mask = 3'd3;
      default: tab_mask = 3'd7;
    endcase
  end

  always_comb begin
    out_byte  = byte_r;
    sts.empty = eof_r && (binary_mode_r || no_form_feed_r);
    sts.last  = 1'b1;
    priority if (eof_r) begin
      out_byte = ptbf_pkg::CH_FF;
    end else if (binary_mode_r) begin
      out_byte = byte_r;
    end else if (is_lf && !prev_cr_r && !lf_cr_sent_r) begin
      // insert CR ahead of a bare LF
      out_byte = ptbf_pkg::CH_CR;
      sts.last = 1'b0;
    end else if (is_tab) begin
      out_byte = ptbf_pkg::CH_SPACE;
      sts.last = ((col_inc & tab_mask) == 3'd0);
    end else begin
      out_byte = byte_r;
    end
  end

  always_comb begin
    col_nxt        = col_r;
    prev_cr_nxt    = prev_cr_r;
    lf_cr_sent_nxt = lf_cr_sent_r;
    if (cmd.load) begin
      lf_cr_sent_nxt = 1'b0;
    end else if (cmd.step) begin
      priority if (eof_r) begin
        col_nxt     = 3'd0;
        prev_cr_nxt = 1'b0;
      end else if (binary_mode_r) begin
        prev_cr_nxt = is_cr;
      end else if (is_cr) begin
        prev_cr_nxt = 1'b1;
      end else if (is_lf) begin
        if (!prev_cr_r && !lf_cr_sent_r) begin
          lf_cr_sent_nxt = 1'b1;
        end else begin
          col_nxt     = 3'd0;
          prev_cr_nxt = 1'b0;
        end
      end else begin
        // tab space or any other byte: advance the column
        col_nxt     = col_inc;
        prev_cr_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tab_width_r    <= ptbf_pkg::TAB_WIDTH_RESET;
      binary_mode_r  <= 1'b0;
      no_form_feed_r <= 1'b0;
      col_r          <= 3'd0;
      prev_cr_r      <= 1'b0;
      lf_cr_sent_r   <= 1'b0;
      eof_r          <= 1'b0;
    end else begin
      col_r        <= col_nxt;
      prev_cr_r    <= prev_cr_nxt;
      lf_cr_sent_r <= lf_cr_sent_nxt;
      if (cmd.load) begin
        eof_r <= end_of_file;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          ptbf_pkg::CFG_TAB_WIDTH:    tab_width_r    <= cfg_wdata;
          ptbf_pkg::CFG_BINARY_MODE:  binary_mode_r  <= cfg_wdata[0];
          ptbf_pkg::CFG_NO_FORM_FEED: no_form_feed_r <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      byte_r <= in_byte;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/printer_text_byte_filter.sv -----
// The first printer byte of a request is offered in the cycle after it is
// accepted; further bytes follow one per cycle while the sink is ready.
// A request yields 1 to 8 printer bytes (eight for a full tab stop); an end of
// file with no form feed yields none. No new request is taken until the
// sequencer has walked the single request register through all of them.
// Reset: synchronous rst_n clears column and CR history, tab width 4.
// ----------------------------------------------------------------------------
// printer_text_byte_filter: top level of the printer text byte filter
// Tab expansion, LF to CR LF and end-of-file form feed for a line printer.
// ----------------------------------------------------------------------------
`default_nettype none

module printer_text_byte_filter (
  input  wire                           clk,
  input  wire                           rst_n,
  ptbf_in_if.sink                       in_ch,
  ptbf_out_if.source                    out_ch,
  input  wire                           cfg_we,
  input  wire [ptbf_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire [ptbf_pkg::CfgDataW-1:0]  cfg_wdata
);

  ptbf_pkg::ptbf_cmd_t cmd;
  ptbf_pkg::ptbf_sts_t sts;

  ptbf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  ptbf_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_byte     (in_ch.in_byte),
    .end_of_file (in_ch.end_of_file),
    .cmd         (cmd),
    .sts         (sts),
    .out_byte    (out_ch.out_byte)
  );

  assign out_ch.last_of_run = sts.last;

`ifndef ASSERT_OFF
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid))
    else $error("request taken while a result is offered");

  a_busy_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("second request taken before first is retired");

  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && out_ch.last_of_run) |=> in_ch.ready)
    else $error("not ready after final result");

  a_more_after_mid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && !out_ch.last_of_run) |=> out_ch.valid)
    else $error("run ended without a final result");
`endif

endmodule

`default_nettype wire

// ----- dv/printer_text_byte_filter_tb.sv -----
// ----------------------------------------------------------------------------
// printer_text_byte_filter_tb: self-checking bench of the printer byte filter
// Feeds a short list of edge cases and then a few hundred random text bytes.
// It predicts every printer byte, with its end-of-run flag, and compares the
// results in order while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module printer_text_byte_filter_tb;

  localparam logic [ptbf_pkg::CfgIdxW-1:0] CFG_UNUSED_IDX = 2'd3;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int SETTLE_CYCLES   = 4;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int CHUNK_ITEMS     = 32;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } printer_byte_t;

  typedef enum logic {ROW_REQ, ROW_REG} row_kind_e;

  typedef struct packed {
    row_kind_e                    kind;
    logic [7:0]                   data;     // text byte, or register value
    logic                         eof;
    logic [ptbf_pkg::CfgIdxW-1:0] reg_idx;
    logic                         typed;    // expected bytes given below
    logic [3:0]                   n;
    logic [7:0]                   first;
    logic [7:0]                   rest;
  } stim_row_t;

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_we;
  logic [ptbf_pkg::CfgIdxW-1:0]  cfg_index;
  logic [ptbf_pkg::CfgDataW-1:0] cfg_wdata;

  ptbf_in_if  in_ch ();
  ptbf_out_if out_ch ();

  printer_text_byte_filter uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // predictor copy of registers and state
  logic [3:0] tab_w     = ptbf_pkg::TAB_WIDTH_RESET;
  logic       binary_on = 1'b0;
  logic       ff_off    = 1'b0;
  logic [2:0] col_mod8  = 3'd0;
  logic       after_cr  = 1'b0;

  printer_byte_t run_buf [8];
  printer_byte_t bytes_due [$];
  stim_row_t     dir_tbl [$];

  int fail_count    = 0;
  int cycle_cnt     = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_req      = 1'b0;
  bit hold_seen     = 1'b0;
  int hold_left     = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Fills run_buf with the printer bytes of one request, advances the state.
  function automatic int expand_text_byte(input logic [7:0] b, input logic eof);
    int         n;
    logic [2:0] stop_mask;
    n = 0;
    stop_mask = (tab_w == 4'd1 || tab_w == 4'd2 || tab_w == 4'd4) ?
                tab_w[2:0] - 3'd1 : 3'd7;
    if (eof) begin
      if (!binary_on && !ff_off) begin
        run_buf[n] = '{ptbf_pkg::CH_FF, 1'b0};
        n++;
      end
      col_mod8 = 3'd0;
      after_cr = 1'b0;
    end else if (binary_on) begin
      run_buf[n] = '{b, 1'b0};
      n++;
      after_cr = (b == ptbf_pkg::CH_CR);
    end else begin
      case (b)
        ptbf_pkg::CH_CR: begin
          run_buf[n] = '{b, 1'b0};
          n++;
        end
        ptbf_pkg::CH_LF: begin
          if (!after_cr) begin
            run_buf[n] = '{ptbf_pkg::CH_CR, 1'b0};
            n++;
          end
          run_buf[n] = '{b, 1'b0};
          n++;
          col_mod8 = 3'd0;
        end
        ptbf_pkg::CH_TAB: begin
          do begin
            run_buf[n] = '{ptbf_pkg::CH_SPACE, 1'b0};
            n++;
            col_mod8++;
          end while ((col_mod8 & stop_mask) != 3'd0 && n < 8);
        end
        default: begin
          run_buf[n] = '{b, 1'b0};
          n++;
          col_mod8++;
        end
      endcase
      after_cr = (b == ptbf_pkg::CH_CR);
    end
    if (n > 0) run_buf[n-1].last = 1'b1;
    return n;
  endfunction

  function automatic void post_run(input int n);
    for (int k = 0; k < n; k++) bytes_due.push_back(run_buf[k]);
  endfunction

  function automatic stim_row_t req_row(input logic [7:0] b, input logic eof);
    return '{ROW_REQ, b, eof, '0, 1'b0, 4'd0, 8'h00, 8'h00};
  endfunction

  function automatic stim_row_t typed_row(input logic [7:0] b, input logic eof,
                                          input logic [3:0] n,
                                          input logic [7:0] first,
                                          input logic [7:0] rest);
    return '{ROW_REQ, b, eof, '0, 1'b1, n, first, rest};
  endfunction

  function automatic stim_row_t reg_row(input logic [ptbf_pkg::CfgIdxW-1:0] idx,
                                        input logic [7:0] val);
    return '{ROW_REG, val, 1'b0, idx, 1'b0, 4'd0, 8'h00, 8'h00};
  endfunction

  task automatic send_req(input logic [7:0] b, input logic eof, output int n);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.in_byte     <= b;
    in_ch.end_of_file <= eof;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    n = expand_text_byte(b, eof);
  endtask

  // Drop valid and wait until every printer byte has come out.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (bytes_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Leaves cfg_we high; the caller lowers it after the last write.
  task automatic write_reg(input logic [ptbf_pkg::CfgIdxW-1:0] idx,
                           input logic [ptbf_pkg::CfgDataW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      ptbf_pkg::CFG_TAB_WIDTH:    tab_w = val;
      ptbf_pkg::CFG_BINARY_MODE:  binary_on = val[0];
      ptbf_pkg::CFG_NO_FORM_FEED: ff_off = val[0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [3:0] tab, input logic bin,
                                input logic noff);
    wait_idle();
    write_reg(ptbf_pkg::CFG_TAB_WIDTH, tab);
    write_reg(ptbf_pkg::CFG_BINARY_MODE, {3'b000, bin});
    write_reg(ptbf_pkg::CFG_NO_FORM_FEED, {3'b000, noff});
    cfg_we <= 1'b0;
  endtask

  // result side: random ready, one long hold-off on request, in-order check
  always @(posedge clk) begin
    printer_byte_t due;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (bytes_due.size() == 0) begin
          $error("out_byte: expected none, got %02h", out_ch.out_byte);
          fail_count++;
        end else begin
          due = bytes_due.pop_front();
          if (out_ch.out_byte !== due.data) begin
            $error("out_byte: expected %02h, got %02h", due.data, out_ch.out_byte);
            fail_count++;
          end
          if (out_ch.last_of_run !== due.last) begin
            $error("last_of_run: expected %0b, got %0b", due.last, out_ch.last_of_run);
            fail_count++;
          end
        end
      end
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    int         n;
    int         r;
    logic [7:0] b;
    logic       eof;
    logic       lf_next;
    logic [3:0] tab_pick;
    in_ch.valid       <= 1'b0;
    in_ch.in_byte     <= 8'h00;
    in_ch.end_of_file <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_index         <= '0;
    cfg_wdata         <= '0;
    rst_n             <= 1'b0;
    lf_next = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // column 0, tab width 4 after reset
    dir_tbl.push_back(typed_row(8'h41, 1'b0, 4'd1, 8'h41, 8'h41));
    dir_tbl.push_back(typed_row(ptbf_pkg::CH_TAB, 1'b0, 4'd3,
                                ptbf_pkg::CH_SPACE, ptbf_pkg::CH_SPACE));
    dir_tbl.push_back(typed_row(ptbf_pkg::CH_LF, 1'b0, 4'd2,
                                ptbf_pkg::CH_CR, ptbf_pkg::CH_LF));
    dir_tbl.push_back(typed_row(ptbf_pkg::CH_CR, 1'b0, 4'd1,
                                ptbf_pkg::CH_CR, ptbf_pkg::CH_CR));
    dir_tbl.push_back(typed_row(ptbf_pkg::CH_LF, 1'b0, 4'd1,
                                ptbf_pkg::CH_LF, ptbf_pkg::CH_LF));
    dir_tbl.push_back(typed_row(8'h00, 1'b0, 4'd1, 8'h00, 8'h00));
    dir_tbl.push_back(typed_row(8'hFF, 1'b0, 4'd1, 8'hFF, 8'hFF));
    dir_tbl.push_back(typed_row(8'hFF, 1'b1, 4'd1,
                                ptbf_pkg::CH_FF, ptbf_pkg::CH_FF));
    dir_tbl.push_back(typed_row(ptbf_pkg::CH_TAB, 1'b0, 4'd4,
                                ptbf_pkg::CH_SPACE, ptbf_pkg::CH_SPACE));
    dir_tbl.push_back(reg_row(ptbf_pkg::CFG_TAB_WIDTH, 8'd8));
    dir_tbl.push_back(req_row(ptbf_pkg::CH_TAB, 1'b0));
    dir_tbl.push_back(typed_row(ptbf_pkg::CH_TAB, 1'b0, 4'd8,
                                ptbf_pkg::CH_SPACE, ptbf_pkg::CH_SPACE));
    dir_tbl.push_back(reg_row(ptbf_pkg::CFG_TAB_WIDTH, 8'd1));
    dir_tbl.push_back(typed_row(ptbf_pkg::CH_TAB, 1'b0, 4'd1,
                                ptbf_pkg::CH_SPACE, ptbf_pkg::CH_SPACE));
    dir_tbl.push_back(reg_row(ptbf_pkg::CFG_TAB_WIDTH, 8'd2));
    dir_tbl.push_back(req_row(8'h5A, 1'b0));
    dir_tbl.push_back(req_row(ptbf_pkg::CH_TAB, 1'b0));
    // unused widths act as 8
    dir_tbl.push_back(reg_row(ptbf_pkg::CFG_TAB_WIDTH, 8'd0));
    dir_tbl.push_back(req_row(ptbf_pkg::CH_TAB, 1'b0));
    dir_tbl.push_back(reg_row(ptbf_pkg::CFG_TAB_WIDTH, 8'd15));
    dir_tbl.push_back(req_row(8'h7E, 1'b0));
    dir_tbl.push_back(req_row(ptbf_pkg::CH_TAB, 1'b0));
    dir_tbl.push_back(reg_row(ptbf_pkg::CFG_NO_FORM_FEED, 8'hF));
    dir_tbl.push_back(typed_row(8'h00, 1'b1, 4'd0, 8'h00, 8'h00));
    dir_tbl.push_back(reg_row(ptbf_pkg::CFG_BINARY_MODE, 8'd1));
    dir_tbl.push_back(reg_row(ptbf_pkg::CFG_NO_FORM_FEED, 8'd0));
    dir_tbl.push_back(typed_row(ptbf_pkg::CH_TAB, 1'b0, 4'd1,
                                ptbf_pkg::CH_TAB, ptbf_pkg::CH_TAB));
    dir_tbl.push_back(typed_row(ptbf_pkg::CH_CR, 1'b0, 4'd1,
                                ptbf_pkg::CH_CR, ptbf_pkg::CH_CR));
    dir_tbl.push_back(typed_row(ptbf_pkg::CH_LF, 1'b0, 4'd1,
                                ptbf_pkg::CH_LF, ptbf_pkg::CH_LF));
    dir_tbl.push_back(typed_row(8'h55, 1'b1, 4'd0, 8'h00, 8'h00));
    dir_tbl.push_back(typed_row(ptbf_pkg::CH_CR, 1'b0, 4'd1,
                                ptbf_pkg::CH_CR, ptbf_pkg::CH_CR));
    // back to text; a binary CR still suppresses the inserted CR
    dir_tbl.push_back(reg_row(ptbf_pkg::CFG_BINARY_MODE, 8'd0));
    dir_tbl.push_back(reg_row(CFG_UNUSED_IDX, 8'hF));
    dir_tbl.push_back(reg_row(ptbf_pkg::CFG_TAB_WIDTH, 8'd4));
    dir_tbl.push_back(req_row(ptbf_pkg::CH_LF, 1'b0));
    dir_tbl.push_back(req_row(ptbf_pkg::CH_LF, 1'b0));
    dir_tbl.push_back(req_row(8'h00, 1'b1));

    send_idle_pct = 31;
    recv_idle_pct = 62;
    foreach (dir_tbl[i]) begin
      if (dir_tbl[i].kind == ROW_REG) begin
        if (i == 0 || dir_tbl[i-1].kind != ROW_REG) wait_idle();
        write_reg(dir_tbl[i].reg_idx, dir_tbl[i].data[ptbf_pkg::CfgDataW-1:0]);
        if (i == dir_tbl.size() - 1 || dir_tbl[i+1].kind != ROW_REG) cfg_we <= 1'b0;
      end else begin
        send_req(dir_tbl[i].data, dir_tbl[i].eof, n);
        if (dir_tbl[i].typed) begin
          n = dir_tbl[i].n;
          for (int k = 0; k < n; k++)
            run_buf[k] = '{(k == 0) ? dir_tbl[i].first : dir_tbl[i].rest, k == n - 1};
        end
        post_run(n);
      end
    end

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin send_idle_pct = 31; recv_idle_pct = 62; end
        1: begin send_idle_pct = 62; recv_idle_pct = 31; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (int ck = 0; ck < 3; ck++) begin
        case ($urandom_range(0, 5))
          0: tab_pick = 4'd1;
          1: tab_pick = 4'd2;
          2: tab_pick = 4'd4;
          3: tab_pick = 4'd8;
          default: tab_pick = 4'($urandom_range(0, 15));
        endcase
        apply_settings(tab_pick, $urandom_range(0, 4) == 0, 1'($urandom_range(0, 1)));
        // hold off the printer side while requests keep coming
        if (ph == 2 && ck == 0) hold_req = ~hold_req;
        for (int it = 0; it < CHUNK_ITEMS; it++) begin
          if (ph == 0 && ck == 1 && it == CHUNK_ITEMS / 2) wait_idle();
          r = $urandom_range(0, 99);
          eof = 1'b0;
          if (lf_next) begin
            b = ptbf_pkg::CH_LF;
            lf_next = 1'b0;
          end else if (r < 5) begin
            b = 8'($urandom_range(0, 255));
            eof = 1'b1;
          end else if (r < 15) begin
            b = ptbf_pkg::CH_TAB;
          end else if (r < 22) begin
            b = ptbf_pkg::CH_LF;
          end else if (r < 28) begin
            b = ptbf_pkg::CH_CR;
            lf_next = 1'($urandom_range(0, 1));
          end else if (r < 43) begin
            b = 8'($urandom_range(0, 255));
          end else begin
            b = 8'($urandom_range(8'h20, 8'h7E));
          end
          send_req(b, eof, n);
          post_run(n);
        end
      end
    end

    wait_idle();
    if (fail_count == 0 && bytes_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
